### rtl/odd_even_transposition_sorter_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the transposition sorter.
// Each macro expects signals named clk and rst_n in the calling module.
// ---------------------------------------------------------------------------
`ifndef ODD_EVEN_TRANSPOSITION_SORTER_DEFINES_SVH
`define ODD_EVEN_TRANSPOSITION_SORTER_DEFINES_SVH

// Condition holds at every edge outside reset.
`define OETS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define OETS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define OETS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/oets_pkg.sv
// ---------------------------------------------------------------------------
// oets_pkg
// Shared widths, defaults, sequencer states and status types.
// ---------------------------------------------------------------------------
package oets_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned MAX_ELEMS_DEF = 64;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } seq_state_t;

  // Status from the sequencer to the output register.
  typedef struct packed {
    logic load;
    logic last;
    logic ovf;
  } emit_t;

endpackage

### rtl/oets_in_if.sv
// ---------------------------------------------------------------------------
// oets_in_if
// Input channel: one signed element per transfer, with end-of-set mark.
// ---------------------------------------------------------------------------
interface oets_in_if;
  import oets_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);

endinterface

### rtl/oets_out_if.sv
// ---------------------------------------------------------------------------
// oets_out_if
// Result channel: one sorted element per transfer, with flags.
// ---------------------------------------------------------------------------
interface oets_out_if;
  import oets_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_result;
  logic                     overflowed;

  modport source (output valid, output sorted_value, output last_result,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input last_result,
                  input overflowed, output ready);

endinterface

### rtl/odd_even_transposition_sorter.sv
// ---------------------------------------------------------------------------
// odd_even_transposition_sorter
// Collects a set of signed elements, sorts it in place, returns it ascending.
// ---------------------------------------------------------------------------
// Elements arrive one per input transfer and are written to an on-chip store
// of MAX_ELEMS entries; elements beyond capacity are dropped and every result
// of that set carries the overflowed flag. The transfer marked last_item ends
// the set (it is still taken when the store is full). The block then runs
// rounds of compare-exchange over the store, even pairs then odd pairs, until
// a round makes no exchange, and streams the set out in ascending order with
// last_result on the final element. Loading takes one element per cycle.
// Each pair checked in a pass takes a store read, then a compare; an
// exchange adds a separate write, because the store has a single write
// port and an exchange writes two entries; each pass closes with a read
// that finds no pair left. A set of N elements needs at most about N/2
// rounds plus one clean round. Read-out takes a store read, then a
// hand-over into the output register once it is free. No new element is
// taken until the final result of a set has been handed over.
// ---------------------------------------------------------------------------
module odd_even_transposition_sorter #(
  parameter int unsigned MAX_ELEMS = oets_pkg::MAX_ELEMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  oets_in_if.sink           in_ch,
  oets_out_if.source        out_ch
);
  import oets_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ELEMS);

  // Store port between sequencer and memory.
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [IDX_W-1:0]         mem_raddr_a;
  logic [IDX_W-1:0]         mem_raddr_b;
  logic signed [DATA_W-1:0] rd_a;
  logic signed [DATA_W-1:0] rd_b;

  emit_t emit;
  logic  out_free;

  // Output register state.
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_last_r;
  logic                     out_ovf_r;

  oets_store #(
    .DEPTH (MAX_ELEMS)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  oets_seq #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_last     (in_ch.last_item),
    .in_value    (in_ch.value),
    .in_ready    (in_ch.ready),
    .out_free    (out_free),
    .emit        (emit),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .rd_a        (rd_a),
    .rd_b        (rd_b)
  );

  // The register is free when empty or when its transfer completes now.
  assign out_free = !out_valid_r || out_ch.ready;

  // Hold valid until the transfer; drop it once taken with nothing behind.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload: capture the store read data with its flags.
  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_value_r <= rd_a;
      out_last_r  <= emit.last;
      out_ovf_r   <= emit.ovf;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_value_r;
  assign out_ch.last_result  = out_last_r;
  assign out_ch.overflowed   = out_ovf_r;

endmodule

### rtl/oets_store.sv
// ---------------------------------------------------------------------------
// oets_store
// Element store: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module oets_store #(
  parameter  int unsigned DEPTH  = oets_pkg::MAX_ELEMS_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [ADDR_W-1:0]                  waddr,
  input  logic signed [oets_pkg::DATA_W-1:0] wdata,
  input  logic                               re,
  input  logic [ADDR_W-1:0]                  raddr_a,
  input  logic [ADDR_W-1:0]                  raddr_b,
  output logic signed [oets_pkg::DATA_W-1:0] rdata_a,
  output logic signed [oets_pkg::DATA_W-1:0] rdata_b
);
  import oets_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/oets_seq.sv
// ---------------------------------------------------------------------------
// oets_seq
// Sequencer: loads the store, runs exchange rounds, reads results out.
// ---------------------------------------------------------------------------
`include "odd_even_transposition_sorter_defines.svh"

module oets_seq #(
  parameter  int unsigned MAX_ELEMS = oets_pkg::MAX_ELEMS_DEF,
  localparam int unsigned IDX_W     = $clog2(MAX_ELEMS)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_last,
  input  logic signed [oets_pkg::DATA_W-1:0] in_value,
  output logic                               in_ready,
  input  logic                               out_free,
  output oets_pkg::emit_t                    emit,
  output logic                               mem_we,
  output logic [IDX_W-1:0]                   mem_waddr,
  output logic signed [oets_pkg::DATA_W-1:0] mem_wdata,
  output logic                               mem_re,
  output logic [IDX_W-1:0]                   mem_raddr_a,
  output logic [IDX_W-1:0]                   mem_raddr_b,
  input  logic signed [oets_pkg::DATA_W-1:0] rd_a,
  input  logic signed [oets_pkg::DATA_W-1:0] rd_b
);
  import oets_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ELEMS + 1);

  seq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             odd_r, odd_nxt;
  logic             swap_r, swap_nxt;
  logic             ovf_r, ovf_nxt;

  logic             in_xfer;
  logic             has_room;
  logic             pair_ok;
  logic             gt;
  logic             emit_last;
  logic [CNT_W-1:0] j_plus1;

  assign in_xfer   = (state_r == ST_LOAD) && in_valid;
  assign has_room  = count_r < CNT_W'(MAX_ELEMS);
  assign pair_ok   = ({1'b0, j_r} + (CNT_W + 1)'(1)) < {1'b0, count_r};
  assign gt        = rd_a > rd_b;
  assign emit_last = (k_r + CNT_W'(1)) == count_r;
  assign j_plus1   = j_r + CNT_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last) state_nxt = ST_SORT_RD;
      end
      ST_SORT_RD: begin
        if (pair_ok) begin
          state_nxt = ST_SORT_CMP;
        end else if (odd_r && !swap_r) begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_SORT_CMP: begin
        state_nxt = gt ? ST_SORT_WR : ST_SORT_RD;
      end
      ST_SORT_WR: begin
        state_nxt = ST_SORT_RD;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_free) state_nxt = emit_last ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Outputs: handshake, store port and emit status.
  always_comb begin
    in_ready    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = count_r[IDX_W-1:0];
    mem_wdata   = in_value;
    mem_re      = 1'b0;
    mem_raddr_a = j_r[IDX_W-1:0];
    mem_raddr_b = j_plus1[IDX_W-1:0];
    emit.load   = 1'b0;
    emit.last   = emit_last;
    emit.ovf    = ovf_r;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        mem_we   = in_valid && has_room;
      end
      ST_SORT_RD: begin
        mem_re = pair_ok;
      end
      ST_SORT_CMP: begin
        // left slot takes the smaller value
        mem_we    = gt;
        mem_waddr = j_r[IDX_W-1:0];
        mem_wdata = rd_b;
      end
      ST_SORT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_plus1[IDX_W-1:0];
        mem_wdata = rd_a;
      end
      ST_EMIT_RD: begin
        mem_re      = 1'b1;
        mem_raddr_a = k_r[IDX_W-1:0];
      end
      ST_EMIT_WAIT: begin
        emit.load = out_free;
      end
      default: ;
    endcase
  end

  // Counters and flags.
  always_comb begin
    count_nxt = count_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    odd_nxt   = odd_r;
    swap_nxt  = swap_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (has_room) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            j_nxt    = '0;
            odd_nxt  = 1'b0;
            swap_nxt = 1'b0;
          end
        end
      end
      ST_SORT_RD: begin
        if (!pair_ok) begin
          if (!odd_r) begin
            odd_nxt = 1'b1;
            j_nxt   = CNT_W'(1);
          end else if (swap_r) begin
            odd_nxt  = 1'b0;
            j_nxt    = '0;
            swap_nxt = 1'b0;
          end else begin
            k_nxt = '0;
          end
        end
      end
      ST_SORT_CMP: begin
        if (gt) begin
          swap_nxt = 1'b1;
        end else begin
          j_nxt = j_r + CNT_W'(2);
        end
      end
      ST_SORT_WR: begin
        j_nxt = j_r + CNT_W'(2);
      end
      ST_EMIT_WAIT: begin
        if (out_free) begin
          if (emit_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            swap_nxt  = 1'b0;
          end else begin
            k_nxt = k_r + CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      j_r     <= '0;
      k_r     <= '0;
      odd_r   <= 1'b0;
      swap_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      odd_r   <= odd_nxt;
      swap_r  <= swap_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  `OETS_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(MAX_ELEMS), "count beyond capacity")
  `OETS_ASSERT_SAME(a_wr_after_cmp, state_r == ST_SORT_WR, $past(state_r) == ST_SORT_CMP && $past(gt), "second write without exchange")
  `OETS_ASSERT_NEXT(a_swap_marked, state_r == ST_SORT_CMP && mem_we, swap_r, "exchange not recorded")
  `OETS_ASSERT_SAME(a_emit_clean, state_r == ST_SORT_RD && state_nxt == ST_EMIT_RD, !swap_r && odd_r, "read-out after exchanging round")
  `OETS_ASSERT_NEXT(a_set_closed, emit.load && emit.last, count_r == '0 && !ovf_r && state_r == ST_LOAD, "set not cleared after final result")

endmodule
